@@ hdl/sha1_hash_core_macros.svh @@
// Assertion macros shared by the SHA-1 hash core RTL.
// Needs nothing but a clock and an active-low reset at the place of use.
`ifndef SHA1_HASH_CORE_MACROS_SVH
`define SHA1_HASH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHA1_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHA1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/sha1_pkg.sv @@
// Shared types and constants of the SHA-1 hash core.
// Used by the controller, the datapath, the top level and the testbench.
package sha1_pkg;

	localparam int WORD_W     = 32;
	localparam int WORDS      = 16;
	localparam int CHAIN_N    = 5;
	localparam int FILL_W     = 6;
	localparam int LEN_W      = 64;
	localparam int ROUND_W    = 7;
	localparam int ROUNDS     = 80;

	localparam logic [FILL_W-1:0]  FILL_LAST   = 6'd63;
	localparam logic [FILL_W-1:0]  FILL_LENPOS = 6'd56;
	localparam logic [ROUND_W-1:0] ROUND_LAST  = 7'(ROUNDS - 1);
	localparam logic [ROUND_W-1:0] ROUND_F1    = 7'd20;
	localparam logic [ROUND_W-1:0] ROUND_F2    = 7'd40;
	localparam logic [ROUND_W-1:0] ROUND_F3    = 7'd60;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [WORD_W-1:0] IV [CHAIN_N] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
	localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
	localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
	localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_MARK,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SEL_INPUT,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef enum logic [1:0] {
		FN_CHOOSE,
		FN_PARITY_A,
		FN_MAJORITY,
		FN_PARITY_B
	} round_fn_t;

	typedef struct packed {
		logic      shift_en;
		byte_sel_t byte_sel;
		logic      count_en;
		logic      len_load;
		logic      round_en;
		round_fn_t round_fn;
		logic      add_en;
		logic      restart;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic fill_last;
		logic fill_len;
		logic fill_zero;
	} status_t;

endpackage

@@ hdl/sha1_if.sv @@
// Valid/ready channel interfaces of the SHA-1 hash core: message items in,
// digest items out. Depends on nothing but the SystemVerilog language.
interface sha1_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word0;
	logic [31:0] digest_word1;
	logic [31:0] digest_word2;
	logic [31:0] digest_word3;
	logic [31:0] digest_word4;

	modport source (output valid, digest_word0, digest_word1, digest_word2, digest_word3,
		digest_word4, input ready);
	modport sink (input valid, digest_word0, digest_word1, digest_word2, digest_word3,
		digest_word4, output ready);
endinterface

@@ hdl/sha1_ctrl.sv @@
// Controller of the SHA-1 hash core: sequences byte intake, padding, rounds
// and digest hand-off. Depends on sha1_pkg and sha1_hash_core_macros.svh.
`include "sha1_hash_core_macros.svh"

module sha1_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_present,
	input  logic                 in_end,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  sha1_pkg::status_t    status,
	output sha1_pkg::cmd_t       cmd
);

	sha1_pkg::state_t state_q, state_d;
	sha1_pkg::state_t ret_q, ret_d;
	logic [sha1_pkg::ROUND_W-1:0] round_q;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign in_ready  = (state_q == sha1_pkg::ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha1_pkg::ST_IDLE;
			ret_q       <= sha1_pkg::ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (state_q == sha1_pkg::ST_ROUND) begin
				round_q <= round_q + 1'b1;
			end else begin
				round_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Every compression returns through ret_q to wherever the message stood.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				if (accept && in_present && status.fill_last) begin
					state_d = sha1_pkg::ST_ROUND;
					ret_d   = in_end ? sha1_pkg::ST_PAD_MARK : sha1_pkg::ST_IDLE;
				end else if (accept && in_end) begin
					state_d = sha1_pkg::ST_PAD_MARK;
				end
			end
			sha1_pkg::ST_PAD_MARK: begin
				if (status.fill_last) begin
					state_d = sha1_pkg::ST_ROUND;
					ret_d   = sha1_pkg::ST_PAD_ZERO;
				end else begin
					state_d = sha1_pkg::ST_PAD_ZERO;
				end
			end
			sha1_pkg::ST_PAD_ZERO: begin
				if (status.fill_len) begin
					state_d = sha1_pkg::ST_PAD_LEN;
				end else if (status.fill_last) begin
					state_d = sha1_pkg::ST_ROUND;
					ret_d   = sha1_pkg::ST_PAD_ZERO;
				end
			end
			sha1_pkg::ST_PAD_LEN: begin
				if (status.fill_last) begin
					state_d = sha1_pkg::ST_ROUND;
					ret_d   = sha1_pkg::ST_DONE;
				end
			end
			sha1_pkg::ST_ROUND: begin
				if (round_q == sha1_pkg::ROUND_LAST) begin
					state_d = sha1_pkg::ST_ADD;
				end
			end
			sha1_pkg::ST_ADD: begin
				state_d = ret_q;
			end
			sha1_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = sha1_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sha1_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.byte_sel = sha1_pkg::SEL_INPUT;
		cmd.round_fn = sha1_pkg::FN_CHOOSE;
		case (state_q)
			sha1_pkg::ST_IDLE: begin
				cmd.shift_en = accept && in_present;
				cmd.count_en = accept && in_present;
			end
			sha1_pkg::ST_PAD_MARK: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = sha1_pkg::SEL_MARK;
				cmd.len_load = 1'b1;
			end
			sha1_pkg::ST_PAD_ZERO: begin
				cmd.shift_en = !status.fill_len;
				cmd.byte_sel = sha1_pkg::SEL_ZERO;
			end
			sha1_pkg::ST_PAD_LEN: begin
				cmd.shift_en = 1'b1;
				cmd.byte_sel = sha1_pkg::SEL_LEN;
			end
			sha1_pkg::ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (round_q < sha1_pkg::ROUND_F1) begin
					cmd.round_fn = sha1_pkg::FN_CHOOSE;
				end else if (round_q < sha1_pkg::ROUND_F2) begin
					cmd.round_fn = sha1_pkg::FN_PARITY_A;
				end else if (round_q < sha1_pkg::ROUND_F3) begin
					cmd.round_fn = sha1_pkg::FN_MAJORITY;
				end else begin
					cmd.round_fn = sha1_pkg::FN_PARITY_B;
				end
			end
			sha1_pkg::ST_ADD: begin
				cmd.add_en = 1'b1;
			end
			sha1_pkg::ST_DONE: begin
				cmd.out_load = out_free;
				cmd.restart  = out_free;
			end
			default: begin
				cmd.shift_en = 1'b0;
			end
		endcase
	end

	`SHA1_ASSERT_SAME(a_round_bound, clk, arst_n, state_q == sha1_pkg::ST_ROUND,
		round_q <= sha1_pkg::ROUND_LAST, "round counter ran past the last round")
	`SHA1_ASSERT_SAME(a_block_empty, clk, arst_n,
		state_q == sha1_pkg::ST_ROUND || state_q == sha1_pkg::ST_ADD,
		status.fill_zero, "compression started on a partly filled block")
	`SHA1_ASSERT_NEXT(a_digest_src, clk, arst_n, cmd.out_load,
		out_valid_q && state_q == sha1_pkg::ST_IDLE, "digest item not presented after load")

endmodule

@@ hdl/sha1_dp.sv @@
// Datapath of the SHA-1 hash core: message schedule window, round logic,
// chaining words, bit counter and digest register. Depends on sha1_pkg.
module sha1_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            data_byte,
	input  sha1_pkg::cmd_t        cmd,
	output sha1_pkg::status_t     status,
	output logic [31:0]           digest [sha1_pkg::CHAIN_N]
);

	localparam int WIN_W = sha1_pkg::WORDS * sha1_pkg::WORD_W;

	// Window word 15 holds w[t], word 0 holds w[t+15]; bytes enter at the bottom.
	logic [sha1_pkg::WORDS-1:0][sha1_pkg::WORD_W-1:0] win_q;
	logic [sha1_pkg::WORD_W-1:0] chain_q [sha1_pkg::CHAIN_N];
	logic [sha1_pkg::WORD_W-1:0] a_q, b_q, c_q, d_q, e_q;
	logic [sha1_pkg::WORD_W-1:0] digest_q [sha1_pkg::CHAIN_N];
	logic [sha1_pkg::FILL_W-1:0] fill_q;
	logic [sha1_pkg::LEN_W-1:0]  bitcnt_q;
	logic [sha1_pkg::LEN_W-1:0]  len_q;

	logic [7:0] byte_in;
	logic [sha1_pkg::WORD_W-1:0] w_mix, w_new, f_val, k_val, t_val;

	always_comb begin
		case (cmd.byte_sel)
			sha1_pkg::SEL_INPUT: byte_in = data_byte;
			sha1_pkg::SEL_MARK:  byte_in = sha1_pkg::PAD_BYTE;
			sha1_pkg::SEL_ZERO:  byte_in = 8'h00;
			sha1_pkg::SEL_LEN:   byte_in = len_q[sha1_pkg::LEN_W-1 -: 8];
			default:             byte_in = 8'h00;
		endcase
	end

	assign w_mix = win_q[2] ^ win_q[7] ^ win_q[13] ^ win_q[15];
	assign w_new = {w_mix[30:0], w_mix[31]};

	always_comb begin
		case (cmd.round_fn)
			sha1_pkg::FN_CHOOSE: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				k_val = sha1_pkg::K0;
			end
			sha1_pkg::FN_PARITY_A: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = sha1_pkg::K1;
			end
			sha1_pkg::FN_MAJORITY: begin
				f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k_val = sha1_pkg::K2;
			end
			sha1_pkg::FN_PARITY_B: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = sha1_pkg::K3;
			end
			default: begin
				f_val = b_q ^ c_q ^ d_q;
				k_val = sha1_pkg::K3;
			end
		endcase
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + win_q[15];

	always_ff @(posedge clk) begin
		if (cmd.shift_en) begin
			win_q <= (win_q << 8) | {{(WIN_W - 8){1'b0}}, byte_in};
		end else if (cmd.round_en) begin
			win_q <= {win_q[sha1_pkg::WORDS-2:0], w_new};
		end
		if (cmd.len_load) begin
			len_q <= bitcnt_q;
		end else if (cmd.shift_en && cmd.byte_sel == sha1_pkg::SEL_LEN) begin
			len_q <= len_q << 8;
		end
		if (cmd.out_load) begin
			digest_q <= chain_q;
		end
	end

	// The working words always equal the chain outside a compression.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q  <= sha1_pkg::IV;
			a_q      <= sha1_pkg::IV[0];
			b_q      <= sha1_pkg::IV[1];
			c_q      <= sha1_pkg::IV[2];
			d_q      <= sha1_pkg::IV[3];
			e_q      <= sha1_pkg::IV[4];
			fill_q   <= '0;
			bitcnt_q <= '0;
		end else begin
			if (cmd.shift_en) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.restart) begin
				bitcnt_q <= '0;
			end else if (cmd.count_en) begin
				bitcnt_q <= bitcnt_q + sha1_pkg::LEN_W'(8);
			end
			if (cmd.restart) begin
				chain_q <= sha1_pkg::IV;
				a_q     <= sha1_pkg::IV[0];
				b_q     <= sha1_pkg::IV[1];
				c_q     <= sha1_pkg::IV[2];
				d_q     <= sha1_pkg::IV[3];
				e_q     <= sha1_pkg::IV[4];
			end else if (cmd.add_en) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				a_q <= chain_q[0] + a_q;
				b_q <= chain_q[1] + b_q;
				c_q <= chain_q[2] + c_q;
				d_q <= chain_q[3] + d_q;
				e_q <= chain_q[4] + e_q;
			end else if (cmd.round_en) begin
				a_q <= t_val;
				b_q <= a_q;
				c_q <= {b_q[1:0], b_q[31:2]};
				d_q <= c_q;
				e_q <= d_q;
			end
		end
	end

	assign status.fill_last = (fill_q == sha1_pkg::FILL_LAST);
	assign status.fill_len  = (fill_q == sha1_pkg::FILL_LENPOS);
	assign status.fill_zero = (fill_q == '0);
	assign digest = digest_q;

endmodule

@@ hdl/sha1_hash_core.sv @@
// Top level of the SHA-1 hash core: joins controller and datapath to the
// item channels. Depends on sha1_pkg, sha1_if, sha1_ctrl and sha1_dp.
//
// msg_in carries one message item per handshake: a byte with its present
// flag and an end-of-message flag. digest_out carries one item, five 32-bit
// words H0..H4, for each item that ends a message.
// Byte items are taken one per cycle until a block of 64 is full; the block
// then runs 80 rounds, one per cycle, and is folded into the chain, while
// msg_in is held off. After an end item msg_in is also held off while the
// core pads one byte per cycle, pausing while a full block is compressed:
// a mark byte, zero bytes up to byte 56 of the block, then the 64-bit bit
// count, most significant byte first. When the mark leaves no room for the
// count, zeros fill out that block and the count goes into the next one;
// an end item that itself completes a block has that block compressed first.
// The digest waits in an output register; while it waits, msg_in keeps
// taking items, and the core stalls only when a further digest is ready
// before the first is taken. Reset returns the chain to the initial hash
// values and empties the block; no clearing pass is needed.
module sha1_hash_core (
	input  logic       clk,
	input  logic       arst_n,
	sha1_in_if.sink    msg_in,
	sha1_out_if.source digest_out
);

	sha1_pkg::cmd_t    cmd;
	sha1_pkg::status_t status;
	logic [31:0]       digest [sha1_pkg::CHAIN_N];

	sha1_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (msg_in.valid),
		.in_present (msg_in.byte_present),
		.in_end     (msg_in.end_of_message),
		.in_ready   (msg_in.ready),
		.out_valid  (digest_out.valid),
		.out_ready  (digest_out.ready),
		.status     (status),
		.cmd        (cmd)
	);

	sha1_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (msg_in.data_byte),
		.cmd       (cmd),
		.status    (status),
		.digest    (digest)
	);

	assign digest_out.digest_word0 = digest[0];
	assign digest_out.digest_word1 = digest[1];
	assign digest_out.digest_word2 = digest[2];
	assign digest_out.digest_word3 = digest[3];
	assign digest_out.digest_word4 = digest[4];

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the streaming SHA-1 hash core.
// Depends on sha1_pkg and the channel interfaces in sha1_if; drives sha1_hash_core.
module tb;

	localparam int LONG_HOLD_CYCLES = 1500;
	localparam int WATCHDOG_LIMIT   = 20000;
	localparam int DRAIN_CYCLES     = 400;
	localparam int RANDOM_ITEMS     = 1550;
	localparam int QUIET_TAIL_ITEMS = 200;

	localparam logic [31:0] INIT_CHAIN [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};
	localparam logic [31:0] ROUND_K [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};
	localparam logic [7:0] MARK_BYTE = 8'h80;

	// Word i of a digest sits in slice [i].
	typedef logic [sha1_pkg::CHAIN_N-1:0][31:0] digest_t;

	class digest_scoreboard;
		logic [31:0] chain [5];
		logic [7:0]  block [64];
		int unsigned fill;
		logic [63:0] bit_count;
		digest_t     pending_digests [$];
		int unsigned failures;

		function new();
			failures = 0;
			restart();
		endfunction

		function void restart();
			chain = INIT_CHAIN;
			fill = 0;
			bit_count = '0;
		endfunction

		function logic [31:0] rotl(logic [31:0] v, int unsigned s);
			return (v << s) | (v >> (32 - s));
		endfunction

		function void fold_block();
			logic [31:0] w [80];
			logic [31:0] a, b, c, d, e, f, tmp;
			for (int t = 0; t < 16; t++)
				w[t] = {block[4*t], block[4*t+1], block[4*t+2], block[4*t+3]};
			for (int t = 16; t < 80; t++)
				w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int t = 0; t < 80; t++) begin
				case (t / 20)
					0: begin
						f = (b & c) | (~b & d);
					end
					2: begin
						f = (b & c) | (b & d) | (c & d);
					end
					default: begin
						f = b ^ c ^ d;
					end
				endcase
				tmp = rotl(a, 5) + f + e + ROUND_K[t / 20] + w[t];
				e = d;
				d = c;
				c = rotl(b, 30);
				b = a;
				a = tmp;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		// Notes one accepted message item and queues the digest it completes.
		function void absorb_item(logic [7:0] data, logic present, logic last);
			int unsigned pos;
			digest_t     digest;
			if (present) begin
				block[fill] = data;
				fill = (fill + 1) % 64;
				bit_count += 64'd8;
				if (fill == 0)
					fold_block();
			end
			if (!last)
				return;
			pos = fill;
			block[pos] = MARK_BYTE;
			pos++;
			// No room left for the length, so the padding spills into a second block.
			if (pos > 56) begin
				while (pos < 64) begin
					block[pos] = 8'h00;
					pos++;
				end
				fold_block();
				pos = 0;
			end
			while (pos < 56) begin
				block[pos] = 8'h00;
				pos++;
			end
			for (int i = 0; i < 8; i++)
				block[56 + i] = bit_count[8 * (7 - i) +: 8];
			fold_block();
			for (int i = 0; i < sha1_pkg::CHAIN_N; i++)
				digest[i] = chain[i];
			pending_digests = {pending_digests, digest};
			restart();
		endfunction

		function void check_digest(digest_t got);
			digest_t want;
			if (pending_digests.size() == 0) begin
				$display("%0t: unexpected digest, expected none, actual %h", $time, got);
				failures++;
				return;
			end
			want = pending_digests.pop_front();
			for (int i = 0; i < sha1_pkg::CHAIN_N; i++) begin
				if (got[i] !== want[i]) begin
					$display("%0t: digest word %0d expected %h actual %h",
						$time, i, want[i], got[i]);
					failures++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sha1_in_if  msg_in_bus ();
	sha1_out_if digest_bus ();

	sha1_hash_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_in     (msg_in_bus),
		.digest_out (digest_bus)
	);

	digest_scoreboard sb;
	bit          idling_on;
	bit          hold_off_request;
	int unsigned item_count;
	int unsigned message_count;
	logic [7:0]  message_bytes [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		msg_in_bus.valid = 1'b0;
		msg_in_bus.data_byte = 8'h00;
		msg_in_bus.byte_present = 1'b0;
		msg_in_bus.end_of_message = 1'b0;
		digest_bus.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
	end

	// Digest receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				digest_bus.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_off_request = 1'b0;
			end
			if (stall_left > 0) begin
				digest_bus.ready <= 1'b0;
				stall_left--;
			end else if (idling_on && $urandom_range(0, 9) == 0) begin
				digest_bus.ready <= 1'b0;
				stall_left = $urandom_range(1, 5) - 1;
			end else begin
				digest_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && digest_bus.valid && digest_bus.ready)
			sb.check_digest({digest_bus.digest_word4, digest_bus.digest_word3,
				digest_bus.digest_word2, digest_bus.digest_word1, digest_bus.digest_word0});
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((msg_in_bus.valid && msg_in_bus.ready) || (digest_bus.valid && digest_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// Called and returns at a falling edge; valid stays high into the next item
	// unless an idle burst is taken.
	task automatic send_item(input logic [7:0] data, input logic present, input logic last);
		int gap;
		if (idling_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 5);
			msg_in_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		msg_in_bus.valid <= 1'b1;
		msg_in_bus.data_byte <= data;
		msg_in_bus.byte_present <= present;
		msg_in_bus.end_of_message <= last;
		do
			@(posedge clk);
		while (!msg_in_bus.ready);
		sb.absorb_item(data, present, last);
		if (present || last)
			item_count++;
		@(negedge clk);
	endtask

	// Sends message_bytes, ending on the last byte or with a separate end item.
	task automatic send_message(input bit end_on_byte);
		int n;
		n = message_bytes.size();
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(message_bytes[i], 1'b1, end_on_byte && i == n - 1);
		end
		if (!end_on_byte || n == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		message_count++;
	endtask

	task automatic wait_all_digests();
		msg_in_bus.valid <= 1'b0;
		while (sb.pending_digests.size() != 0)
			@(negedge clk);
	endtask

	function automatic int pick_length();
		int boundary [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
		int pick;
		pick = $urandom_range(0, 3);
		if (pick < 2)
			return $urandom_range(0, 16);
		else if (pick == 2)
			return boundary[$urandom_range(0, 9)];
		else
			return $urandom_range(0, 130);
	endfunction

	task automatic random_message(input int len);
		message_bytes.delete();
		for (int i = 0; i < len; i++)
			message_bytes = {message_bytes, 8'($urandom_range(0, 255))};
		send_message(1'($urandom_range(0, 1)));
	endtask

	initial begin
		int unsigned start_items;
		bit          hold_done;
		sb = new();
		idling_on = 1'b1;
		hold_off_request = 1'b0;
		item_count = 0;
		message_count = 0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// Empty message, then "abc" ending on its last byte.
		send_item(8'h00, 1'b0, 1'b1);
		message_bytes = '{8'h61, 8'h62, 8'h63};
		send_message(1'b1);
		// Extreme bytes with an ignored item inside, closed by a bare end item.
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		message_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00};
		send_message(1'b0);

		start_items = item_count;
		while (item_count - start_items < RANDOM_ITEMS) begin
			idling_on = (item_count - start_items) < RANDOM_ITEMS - QUIET_TAIL_ITEMS;
			if (!hold_done && message_count == 12) begin
				// Keep offering short messages while the digest side is held off.
				hold_done = 1'b1;
				hold_off_request = 1'b1;
				repeat (8) random_message($urandom_range(0, 4));
				wait_all_digests();
			end else begin
				random_message(pick_length());
			end
		end

		wait_all_digests();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/sha1_pkg.sv
hdl/sha1_if.sv
hdl/sha1_ctrl.sv
hdl/sha1_dp.sv
hdl/sha1_hash_core.sv
sim/tb.sv
